// ===== hdl/cfr_pkg.sv =====
// shared types and constants for the command frame receiver
`default_nettype none

package cfr_pkg;

   localparam int BYTE_W = 8;
   // payload index and frame length width, enough for lengths up to 15
   localparam int LEN_W = 4;
   // csr register index width
   localparam int CSR_IDX_W = 2;

   // frame lengths that carry an update
   localparam logic [LEN_W-1:0] LED_FRAME_LEN = 4'd4;
   localparam logic [LEN_W-1:0] FAN_FRAME_LEN = 4'd1;
   // only the first four payload bytes are ever acted on
   localparam int KEEP_BYTES = 4;
   localparam int KEEP_IDX_W = 2;

   // csr register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_VALUE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LED_CODE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FAN_CODE     = 2'd2;

   // csr reset values
   localparam logic [BYTE_W-1:0] HEADER_VALUE_RST = 8'hAA;
   localparam logic [BYTE_W-1:0] LED_CODE_RST     = 8'h04;
   localparam logic [BYTE_W-1:0] FAN_CODE_RST     = 8'h02;

   // update kind carried on rsp_tuser
   localparam logic KIND_LED = 1'b0;
   localparam logic KIND_FAN = 1'b1;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_LENGTH  = 3'd1,
      PH_COMMAND = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_CRC_LO  = 3'd4,
      PH_CRC_HI  = 3'd5
   } parse_phase_type;

endpackage

`default_nettype wire

// ===== hdl/command_frame_receiver_core.sv =====
// command frame receiver: parses length-prefixed frames and emits actuator updates
//
//   channel | ports            | direction | contents
//   --------+------------------+-----------+----------------------------------------
//   req     | req_t*           | in        | one uart receive event per word
//   rsp     | rsp_t*           | out       | full actuator state after an update
//   csr     | csr_we/index/..  | in        | header value, led and fan command codes
//
// one req word is taken every cycle while req_tready is high; its parser step runs
// in the same cycle and a resulting update lands in the rsp output register in the
// following cycle; req_tready drops only while the output register holds a word that
// rsp_tready does not take; a word that causes no update passes without an output slot
// reset is synchronous and returns the parser to header search, clears the
// actuator levels and restores the csr defaults
`default_nettype none

module command_frame_receiver_core #(
   parameter int MAX_PAYLOAD = 10
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // receive events
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [cfr_pkg::BYTE_W-1:0]          req_tdata,  // [7:0] rx_byte
   input  wire  [1:0]                          req_tuser,  // [0] overrun, [1] byte_valid
   // actuator updates
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [5*cfr_pkg::BYTE_W-1:0]        rsp_tdata,  // [7:0] led_red, [15:8] led_green,
                                                           // [23:16] led_blue,
                                                           // [31:24] led_brightness,
                                                           // [39:32] fan_speed
   output logic                                rsp_tuser,  // [0] update_kind
   // configuration
   input  wire                                 csr_we,
   input  wire  [cfr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [cfr_pkg::BYTE_W-1:0]          csr_wdata
);

   localparam int BW = cfr_pkg::BYTE_W;
   localparam int LW = cfr_pkg::LEN_W;

   // configuration registers
   logic [BW-1:0] header_value_ff;
   logic [BW-1:0] led_code_ff;
   logic [BW-1:0] fan_code_ff;

   // parser state
   cfr_pkg::parse_phase_type phase_ff, phase_in;
   logic [LW-1:0] frame_len_ff, frame_len_in;
   logic [BW-1:0] frame_cmd_ff, frame_cmd_in;
   logic [LW-1:0] pay_idx_ff, pay_idx_in;
   logic [BW-1:0] pay_store_ff [cfr_pkg::KEEP_BYTES];
   logic          pay_we;

   // actuator levels
   logic [BW-1:0] red_ff, red_in;
   logic [BW-1:0] green_ff, green_in;
   logic [BW-1:0] blue_ff, blue_in;
   logic [BW-1:0] bright_ff, bright_in;
   logic [BW-1:0] fan_ff, fan_in;

   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   logic [5*BW-1:0] rsp_data_ff;
   logic            rsp_kind_ff;
   logic            emit;
   logic            emit_kind;

   logic            accept;
   logic            overrun;
   logic            byte_valid;
   logic [BW-1:0]   rx_byte;
   logic [LW-1:0]   idx_next;

   assign overrun    = req_tuser[0];
   assign byte_valid = req_tuser[1];
   assign rx_byte    = req_tdata;

   // take a word unless a finished update is stuck in the output register
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

   assign idx_next = pay_idx_ff + LW'(1);

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         header_value_ff <= cfr_pkg::HEADER_VALUE_RST;
         led_code_ff     <= cfr_pkg::LED_CODE_RST;
         fan_code_ff     <= cfr_pkg::FAN_CODE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            cfr_pkg::CSR_HEADER_VALUE: header_value_ff <= csr_wdata;
            cfr_pkg::CSR_LED_CODE:     led_code_ff     <= csr_wdata;
            cfr_pkg::CSR_FAN_CODE:     fan_code_ff     <= csr_wdata;
            default: ;  // writes past the register list are dropped
         endcase
      end
   end

   // parser step for one word
   always_comb begin
      cfr_pkg::parse_phase_type ph;
      ph           = phase_ff;
      phase_in     = phase_ff;
      frame_len_in = frame_len_ff;
      frame_cmd_in = frame_cmd_ff;
      pay_idx_in   = pay_idx_ff;
      pay_we       = 1'b0;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      bright_in    = bright_ff;
      fan_in       = fan_ff;
      emit         = 1'b0;
      emit_kind    = cfr_pkg::KIND_LED;

      if (accept) begin
         // an overrun restarts header search before the byte is looked at
         if (overrun) begin
            ph       = cfr_pkg::PH_HEADER;
            phase_in = cfr_pkg::PH_HEADER;
         end
         if (byte_valid) begin
            unique case (ph)
               cfr_pkg::PH_HEADER: begin
                  if (rx_byte == header_value_ff) begin
                     phase_in = cfr_pkg::PH_LENGTH;
                  end
               end
               cfr_pkg::PH_LENGTH: begin
                  // zero or oversized length drops the frame
                  if (rx_byte == '0 || rx_byte > BW'(MAX_PAYLOAD)) begin
                     phase_in = cfr_pkg::PH_HEADER;
                  end else begin
                     frame_len_in = rx_byte[LW-1:0];
                     phase_in     = cfr_pkg::PH_COMMAND;
                  end
               end
               cfr_pkg::PH_COMMAND: begin
                  frame_cmd_in = rx_byte;
                  pay_idx_in   = '0;
                  phase_in     = cfr_pkg::PH_PAYLOAD;
               end
               cfr_pkg::PH_PAYLOAD: begin
                  // bytes past the fourth are never acted on, so not kept
                  pay_we     = pay_idx_ff < LW'(cfr_pkg::KEEP_BYTES);
                  pay_idx_in = idx_next;
                  if (idx_next >= frame_len_ff) begin
                     phase_in = cfr_pkg::PH_CRC_LO;
                  end
               end
               cfr_pkg::PH_CRC_LO: begin
                  phase_in = cfr_pkg::PH_CRC_HI;
               end
               cfr_pkg::PH_CRC_HI: begin
                  phase_in = cfr_pkg::PH_HEADER;
                  // led update wins when both codes match the command
                  if (frame_cmd_ff == led_code_ff &&
                      frame_len_ff == cfr_pkg::LED_FRAME_LEN) begin
                     red_in    = pay_store_ff[0];
                     green_in  = pay_store_ff[1];
                     blue_in   = pay_store_ff[2];
                     bright_in = pay_store_ff[3];
                     emit      = 1'b1;
                     emit_kind = cfr_pkg::KIND_LED;
                  end else if (frame_cmd_ff == fan_code_ff &&
                               frame_len_ff == cfr_pkg::FAN_FRAME_LEN) begin
                     fan_in    = pay_store_ff[0];
                     emit      = 1'b1;
                     emit_kind = cfr_pkg::KIND_FAN;
                  end
               end
               default: begin
                  // unused phase codes fall back to header search
                  phase_in = cfr_pkg::PH_HEADER;
               end
            endcase
         end
      end

      // output register: load on an update, clear once taken
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= cfr_pkg::PH_HEADER;
         frame_len_ff <= '0;
         frame_cmd_ff <= '0;
         pay_idx_ff   <= '0;
         red_ff       <= '0;
         green_ff     <= '0;
         blue_ff      <= '0;
         bright_ff    <= '0;
         fan_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         frame_len_ff <= frame_len_in;
         frame_cmd_ff <= frame_cmd_in;
         pay_idx_ff   <= pay_idx_in;
         red_ff       <= red_in;
         green_ff     <= green_in;
         blue_ff      <= blue_in;
         bright_ff    <= bright_in;
         fan_ff       <= fan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload bytes and output word, no reset needed
   always_ff @(posedge clock) begin
      if (pay_we) begin
         pay_store_ff[pay_idx_ff[cfr_pkg::KEEP_IDX_W-1:0]] <= rx_byte;
      end
      if (emit) begin
         rsp_data_ff <= {fan_in, bright_in, blue_in, green_in, red_in};
         rsp_kind_ff <= emit_kind;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/cfr_checker.sv =====
// port-level checks for the command frame receiver, bound to command_frame_receiver_core
`default_nettype none

module cfr_checker (
   input wire                                  clock,
   input wire                                  reset,
   input wire                                  req_tvalid,
   input wire                                  req_tready,
   input wire [1:0]                            req_tuser,
   input wire                                  rsp_tvalid,
   input wire                                  rsp_tready,
   input wire [5*cfr_pkg::BYTE_W-1:0]          rsp_tdata,
   input wire                                  rsp_tuser
);

   // nothing comes out in the cycle after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("rsp word present right after reset");

   // a held word does not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled rsp word changed");

   // a new update follows an accepted req word
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("rsp word with no accepted req word before it");

   // a word with no byte never produces an update
   a_no_byte_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser[1] && (!rsp_tvalid || rsp_tready)
      |=> !rsp_tvalid)
      else $error("update from a word without a byte");

   // intake stalls while the output register is blocked
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("req taken while rsp word is blocked");

endmodule

bind command_frame_receiver_core cfr_checker u_cfr_checker (.*);

`default_nettype wire
